FILE: sv/assert_macros.svh
// Assertion macros for the LED wave diffusion RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LWD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define LWD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/lwd_pkg.sv
// Types, constants and arithmetic helpers for the LED wave diffusion block.
package lwd_pkg;

  localparam int LWD_LED_COUNT = 16;
  localparam int LWD_LEVEL_W   = 8;
  localparam int LWD_POS_W     = 4;
  localparam logic [LWD_LEVEL_W-1:0] LWD_LEVEL_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_INJECT = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2
  } lwd_op_t;

  // One diffused level on its way to the output.
  typedef struct packed {
    logic                   vld;
    logic [LWD_POS_W-1:0]   pos;
    logic [LWD_LEVEL_W-1:0] level;
    logic                   last;
  } lwd_beat_t;

  // floor(x/5) by reciprocal: exact for 8-bit x.
  function automatic logic [LWD_LEVEL_W-1:0] lwd_div5(input logic [LWD_LEVEL_W-1:0] x);
    logic [17:0] prod;
    prod = 18'(x) * 18'd205;
    return prod[17:10];
  endfunction

  // floor(x/255) for x up to 255*255.
  function automatic logic [LWD_LEVEL_W-1:0] lwd_div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // left/5 + self/2 + right/5, held at full scale.
  function automatic logic [LWD_LEVEL_W-1:0] lwd_diffuse(
    input logic [LWD_LEVEL_W-1:0] left,
    input logic [LWD_LEVEL_W-1:0] self,
    input logic [LWD_LEVEL_W-1:0] right
  );
    logic [9:0] s;
    s = 10'(lwd_div5(left)) + 10'(self >> 1) + 10'(lwd_div5(right));
    return (s > 10'(LWD_LEVEL_MAX)) ? LWD_LEVEL_MAX : s[7:0];
  endfunction

endpackage

FILE: sv/led_wave_diffusion.sv
// LED wave diffusion: one wave level per LED in a RAM, diffused and emitted on each tick of a nonzero row.
//
// The block keeps one 8-bit level per LED in a small RAM. An inject beat sets one
// LED to full scale, a clear beat zeroes the whole row, and both complete while
// idle with no output. A tick beat on a row with any nonzero level walks the
// RAM once through its single read port: each entry is read, the new level
// left/5 + self/2 + right/5 is formed from a three-entry window and written back
// in place, scaled by luminosity/255, and sent out in LED order with tlast on the
// final LED. A tick on an all-zero row is accepted and emits nothing. A working
// tick holds off the input until the walk ends (one read per LED, then the RAM
// read register and the right-end step), and its last output beat then passes
// the product and output registers; output backpressure freezes the whole walk.
// Reset and clear take effect at once through per-entry valid bits, so no
// clearing pass is needed. Write luminosity only while the block is idle.
`include "assert_macros.svh"

module led_wave_diffusion
  import lwd_pkg::*;
#(
  parameter int LED_COUNT = LWD_LED_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [1:0] op, [5:2] led_index, [7:6] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [3:0] led_position, [11:4] level, [15:12] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int AW = $clog2(LED_COUNT);
  localparam int CW = $clog2(LED_COUNT + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t                 state_r;
  state_t                 state_nxt;
  logic [CW-1:0]          rd_cnt_r;
  logic                   dv_r;
  logic                   vb_r;
  logic [LED_COUNT-1:0]   valid_r;
  logic                   nz_r;
  logic [LWD_LEVEL_W-1:0] lum_r;

  logic                   in_acc;
  lwd_op_t                in_op;
  logic [LWD_POS_W-1:0]   in_idx;
  logic                   in_range;
  logic                   inj_we;
  logic                   tick_go;
  logic                   adv;
  logic                   walk_issue;
  logic                   ram_re;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [LWD_LEVEL_W-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [LWD_LEVEL_W-1:0] ram_q;
  logic [LWD_LEVEL_W-1:0] rd_level;

  logic                   dif_wr_en;
  logic [AW-1:0]          dif_wr_addr;
  logic [LWD_LEVEL_W-1:0] dif_wr_data;
  logic                   dif_done;
  logic                   dif_nz;
  lwd_beat_t              dif_beat;

  logic [LWD_POS_W-1:0]   o_pos;
  logic [LWD_LEVEL_W-1:0] o_level;

  // Input decode.
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = lwd_op_t'(in_tdata[1:0]);
  assign in_idx    = in_tdata[5:2];
  // Drop an inject aimed past the end of the row.
  assign in_range  = (32'(in_idx) < 32'(LED_COUNT));
  assign inj_we    = in_acc && (in_op == OP_INJECT) && in_range;
  // Skip the walk when every level is zero.
  assign tick_go   = in_acc && (in_op == OP_TICK) && nz_r;

  assign cfg_ready = 1'b1;

  // Advance the walk only when the output register is free or being drained.
  assign adv        = !out_tvalid || out_tready;
  assign walk_issue = (state_r == ST_WALK) && (rd_cnt_r < CW'(LED_COUNT));
  assign ram_re     = adv && walk_issue;
  assign ram_raddr  = rd_cnt_r[AW-1:0];

  // Inject and walk write-back never overlap: inject only happens while idle.
  assign ram_we    = inj_we || dif_wr_en;
  assign ram_waddr = inj_we ? AW'(in_idx) : dif_wr_addr;
  assign ram_wdata = inj_we ? LWD_LEVEL_MAX : dif_wr_data;

  // An entry not written since reset or clear reads as zero.
  assign rd_level = vb_r ? ram_q : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tick_go) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (dif_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_cnt_r <= '0;
      dv_r     <= 1'b0;
      valid_r  <= '0;
      nz_r     <= 1'b0;
      lum_r    <= LWD_LEVEL_MAX;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        lum_r <= cfg_data;
      end
      if (adv) begin
        dv_r <= walk_issue;
        if (walk_issue) begin
          rd_cnt_r <= rd_cnt_r + CW'(1);
        end
      end
      if (dif_wr_en) begin
        valid_r[dif_wr_addr] <= 1'b1;
      end
      if (dif_done) begin
        nz_r <= dif_nz;
      end
      if (in_acc) begin
        unique case (in_op)
          OP_INJECT: begin
            if (in_range) begin
              valid_r[AW'(in_idx)] <= 1'b1;
              nz_r                 <= 1'b1;
            end
          end
          OP_TICK: begin
            if (nz_r) begin
              rd_cnt_r <= '0;
            end
          end
          OP_CLEAR: begin
            valid_r <= '0;
            nz_r    <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Capture the entry's valid bit alongside its read.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      vb_r <= valid_r[ram_raddr];
    end
  end

  lwd_ram #(
    .WIDTH (LWD_LEVEL_W),
    .DEPTH (LED_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  lwd_diffuse #(
    .LED_COUNT (LED_COUNT)
  ) u_diffuse (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .dv      (dv_r),
    .d       (rd_level),
    .wr_en   (dif_wr_en),
    .wr_addr (dif_wr_addr),
    .wr_data (dif_wr_data),
    .done    (dif_done),
    .any_nz  (dif_nz),
    .beat    (dif_beat)
  );

  lwd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .lum       (lum_r),
    .beat      (dif_beat),
    .out_vld   (out_tvalid),
    .out_pos   (o_pos),
    .out_level (o_level),
    .out_last  (out_tlast)
  );

  assign out_tdata = {4'b0, o_level, o_pos};

  `LWD_ASSERT_NXT(a_clear_empties, in_acc && in_op == OP_CLEAR, valid_r == '0 && !nz_r)
  `LWD_ASSERT_IMP(a_last_pos, out_tvalid && out_tlast, out_tdata[3:0] == 4'(LED_COUNT - 1))
  `LWD_ASSERT_IMP(a_freeze_read, !adv, !ram_re)
  `LWD_ASSERT_IMP(a_walk_owns_write, dif_wr_en, state_r == ST_WALK)

endmodule

FILE: sv/lwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/lwd_diffuse.sv
// Three-entry sliding window over the level walk: computes and writes back new levels.
module lwd_diffuse
  import lwd_pkg::*;
#(
  parameter int LED_COUNT = LWD_LED_COUNT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         dv,
  input  logic [LWD_LEVEL_W-1:0]       d,
  output logic                         wr_en,
  output logic [$clog2(LED_COUNT)-1:0] wr_addr,
  output logic [LWD_LEVEL_W-1:0]       wr_data,
  output logic                         done,
  output logic                         any_nz,
  output lwd_beat_t                    beat
);

  localparam int AW = $clog2(LED_COUNT);

  logic                   full_r;
  logic [AW-1:0]          c_r;
  logic [LWD_LEVEL_W-1:0] prev_r;
  logic [LWD_LEVEL_W-1:0] cur_r;
  logic                   acc_r;
  lwd_beat_t              beat_r;

  logic                   at_end;
  logic                   compute;
  logic [LWD_LEVEL_W-1:0] nbr;
  logic [LWD_LEVEL_W-1:0] new_level;

  assign at_end    = (c_r == AW'(LED_COUNT - 1));
  assign compute   = adv && full_r && (dv || at_end);
  // Past the right end the neighbor counts as zero.
  assign nbr       = dv ? d : '0;
  assign new_level = lwd_diffuse(prev_r, cur_r, nbr);

  assign wr_en   = compute;
  assign wr_addr = c_r;
  assign wr_data = new_level;
  assign done    = compute && at_end;
  assign any_nz  = acc_r || (new_level != '0);
  assign beat    = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r     <= 1'b0;
      acc_r      <= 1'b0;
      beat_r.vld <= 1'b0;
    end else if (adv) begin
      beat_r.vld <= compute;
      if (dv) begin
        if (full_r) begin
          acc_r <= any_nz;
        end else begin
          full_r <= 1'b1;
          acc_r  <= 1'b0;
        end
      end else if (done) begin
        full_r <= 1'b0;
      end
    end
  end

  // Window and beat payload: no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      beat_r.pos   <= LWD_POS_W'(c_r);
      beat_r.level <= new_level;
      beat_r.last  <= at_end;
      if (dv) begin
        if (full_r) begin
          prev_r <= cur_r;
          c_r    <= c_r + AW'(1);
        end else begin
          prev_r <= '0;
          c_r    <= '0;
        end
        cur_r <= d;
      end
    end
  end

endmodule

FILE: sv/lwd_scale.sv
// Brightness scaling stages and output register.
module lwd_scale
  import lwd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic [LWD_LEVEL_W-1:0] lum,
  input  lwd_beat_t              beat,
  output logic                   out_vld,
  output logic [LWD_POS_W-1:0]   out_pos,
  output logic [LWD_LEVEL_W-1:0] out_level,
  output logic                   out_last
);

  logic                   p_vld_r;
  logic [15:0]            p_prod_r;
  logic [LWD_POS_W-1:0]   p_pos_r;
  logic                   p_last_r;
  logic                   o_vld_r;
  logic [LWD_POS_W-1:0]   o_pos_r;
  logic [LWD_LEVEL_W-1:0] o_level_r;
  logic                   o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      p_vld_r <= beat.vld;
      o_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_prod_r  <= 16'(beat.level) * 16'(lum);
      p_pos_r   <= beat.pos;
      p_last_r  <= beat.last;
      o_level_r <= lwd_div255(p_prod_r);
      o_pos_r   <= p_pos_r;
      o_last_r  <= p_last_r;
    end
  end

  assign out_vld   = o_vld_r;
  assign out_pos   = o_pos_r;
  assign out_level = o_level_r;
  assign out_last  = o_last_r;

endmodule
